// ===== src/sisf_pkg.sv =====
// Shared types and constants of the stereo shelving filter core.
`timescale 1ns / 1ps

package sisf_pkg;

   localparam int SAMP_W       = 16;
   localparam int COEF_W       = 18;
   localparam int NUM_REGS     = 6;
   localparam int REG_IDX_W    = 3;
   localparam int NUM_LANES    = 2;
   localparam int TAPS_DEFAULT = 3;

   // Accumulator and scaling widths. The accumulator is split into a low
   // unsigned part and a high signed part so that the scaling product fits
   // two small multipliers.
   localparam int ACC_W     = 37;
   localparam int SPLIT_W   = 19;
   localparam int OPND_W    = SPLIT_W + 1;
   localparam int PROD_W    = COEF_W + OPND_W;
   localparam int SUM_W     = PROD_W + SPLIT_W;
   localparam int OUT_SHIFT = 26;
   localparam int YFULL_W   = SUM_W - OUT_SHIFT;

   localparam int SAMP_MAX = 32767;
   localparam int SAMP_MIN = -32768;

   localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (OUT_SHIFT - 1);

   localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(8192);
   localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_B0    = 3'd0,
      REG_B1    = 3'd1,
      REG_B2    = 3'd2,
      REG_A1    = 3'd3,
      REG_A2    = 3'd4,
      REG_RECIP = 3'd5
   } reg_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_SCALE,
      ST_ROUND
   } state_type;

   typedef struct packed {
      logic load;
      logic mul_en;
      logic scale_en;
      logic acc_en;
      logic commit;
   } ctrl_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
      logic signed [COEF_W-1:0] recip;
   } coef_type;

endpackage

// ===== src/stereo_iir_shelving_filter_core.sv =====
// A new frame is taken only once the previous one has been committed; each lane's
// single multiplier pair is used once per tap, once for scaling, and then rounding.
// A finished frame waits in the output register while the next frame is computed.
// Reset (synchronous, active high) zeroes the sample history and loads b0 and
// recip_a0 with 1.0 and all other coefficients with zero.
`timescale 1ns / 1ps

module stereo_iir_shelving_filter_core #(
   parameter int TAPS = sisf_pkg::TAPS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [2*sisf_pkg::SAMP_W-1:0]     req_tdata,   // left in, right in
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [2*sisf_pkg::SAMP_W-1:0]     rsp_tdata,   // left_out, right_out
   input  logic                              csr_we,
   input  logic [sisf_pkg::REG_IDX_W-1:0]    csr_index,
   input  logic [sisf_pkg::COEF_W-1:0]       csr_wdata
);

   localparam int SAMP_W    = sisf_pkg::SAMP_W;
   localparam int NUM_LANES = sisf_pkg::NUM_LANES;
   localparam int STEP_W    = (TAPS > 1) ? $clog2(TAPS) : 1;

   sisf_pkg::coef_type coef_ff, coef_in;
   sisf_pkg::ctrl_type ctrl;
   logic [STEP_W-1:0]  step;
   logic               out_free;

   logic signed [SAMP_W-1:0] lane_in  [NUM_LANES];
   logic signed [SAMP_W-1:0] lane_out [NUM_LANES];

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [NUM_LANES*SAMP_W-1:0] rsp_data_ff, rsp_data_in;

   // Coefficient registers.
   always_comb begin
      coef_in = coef_ff;
      if (csr_we) begin
         unique case (sisf_pkg::reg_idx_type'(csr_index))
            sisf_pkg::REG_B0:    coef_in.b0    = csr_wdata;
            sisf_pkg::REG_B1:    coef_in.b1    = csr_wdata;
            sisf_pkg::REG_B2:    coef_in.b2    = csr_wdata;
            sisf_pkg::REG_A1:    coef_in.a1    = csr_wdata;
            sisf_pkg::REG_A2:    coef_in.a2    = csr_wdata;
            sisf_pkg::REG_RECIP: coef_in.recip = csr_wdata;
            default:             coef_in       = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0    <= sisf_pkg::COEF_ONE;
         coef_ff.b1    <= sisf_pkg::COEF_ZERO;
         coef_ff.b2    <= sisf_pkg::COEF_ZERO;
         coef_ff.a1    <= sisf_pkg::COEF_ZERO;
         coef_ff.a2    <= sisf_pkg::COEF_ZERO;
         coef_ff.recip <= sisf_pkg::COEF_ONE;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   sisf_ctrl #(
      .TAPS(TAPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_free  (out_free),
      .ready     (req_tready),
      .ctrl      (ctrl),
      .step      (step)
   );

   generate
      for (genvar ch = 0; ch < NUM_LANES; ch++) begin : g_lane
         assign lane_in[ch] = req_tdata[ch*SAMP_W +: SAMP_W];

         sisf_lane #(
            .TAPS(TAPS)
         ) u_lane (
            .clock  (clock),
            .reset  (reset),
            .ctrl   (ctrl),
            .step   (step),
            .coef   (coef_ff),
            .sample (lane_in[ch]),
            .y_out  (lane_out[ch])
         );
      end
   endgenerate

   // Both lanes finish together; their results are merged into one transaction.
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (ctrl.commit) begin
         for (int ch = 0; ch < NUM_LANES; ch++) begin
            rsp_data_in[ch*SAMP_W +: SAMP_W] = lane_out[ch];
         end
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A result is only written into a free or draining output register.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result written over an untaken transaction");

   // A new result appears only as the consequence of a commit.
   a_valid_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.commit))
      else $error("output valid without a commit");

   // Once a frame is taken, no other frame is taken until it is committed.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while a frame is in progress");

   // Loading a frame and committing one never coincide.
   a_load_commit_apart: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.load && ctrl.commit))
      else $error("load and commit in the same cycle");

endmodule

// ===== src/sisf_lane.sv =====
// One channel of the filter: shared multiplier pair, accumulator and history.
`timescale 1ns / 1ps

module sisf_lane #(
   parameter int  TAPS   = sisf_pkg::TAPS_DEFAULT,
   localparam int STEP_W = (TAPS > 1) ? $clog2(TAPS) : 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sisf_pkg::ctrl_type                   ctrl,
   input  logic [STEP_W-1:0]                    step,
   input  sisf_pkg::coef_type                   coef,
   input  logic signed [sisf_pkg::SAMP_W-1:0]   sample,
   output logic signed [sisf_pkg::SAMP_W-1:0]   y_out
);

   localparam int SAMP_W  = sisf_pkg::SAMP_W;
   localparam int COEF_W  = sisf_pkg::COEF_W;
   localparam int ACC_W   = sisf_pkg::ACC_W;
   localparam int SPLIT_W = sisf_pkg::SPLIT_W;
   localparam int OPND_W  = sisf_pkg::OPND_W;
   localparam int PROD_W  = sisf_pkg::PROD_W;
   localparam int SUM_W   = sisf_pkg::SUM_W;
   localparam int YFULL_W = sisf_pkg::YFULL_W;

   logic signed [SAMP_W-1:0] x_ff, x_in;
   logic signed [SAMP_W-1:0] x_hist_ff [TAPS-1];
   logic signed [SAMP_W-1:0] x_hist_in [TAPS-1];
   logic signed [SAMP_W-1:0] y_hist_ff [TAPS-1];
   logic signed [SAMP_W-1:0] y_hist_in [TAPS-1];

   logic signed [COEF_W-1:0] b_tap [TAPS];
   logic signed [COEF_W-1:0] a_tap [TAPS];
   logic signed [SAMP_W-1:0] x_tap [TAPS];
   logic signed [SAMP_W-1:0] y_tap [TAPS];

   logic signed [ACC_W-1:0]         acc_ff, acc_in;
   logic signed [ACC_W-SPLIT_W-1:0] acc_hi;
   logic signed [PROD_W-1:0]        pa_ff, pa_in, pb_ff, pb_in;
   logic signed [COEF_W-1:0]        mul_coef_a, mul_coef_b;
   logic signed [OPND_W-1:0]        opnd_a, opnd_b;

   logic signed [SUM_W-1:0]   pa_ext, pb_ext, sum;
   logic signed [YFULL_W-1:0] y_full;
   logic signed [SAMP_W-1:0]  y_sat;

   // Tap k multiplies b_k by the input k frames back and a_k by the output
   // k frames back; there is no feedback term on the current frame.
   assign b_tap[0] = coef.b0;
   assign b_tap[1] = coef.b1;
   assign a_tap[0] = sisf_pkg::COEF_ZERO;
   assign a_tap[1] = coef.a1;
   generate
      if (TAPS > 2) begin : g_second_order
         assign b_tap[2] = coef.b2;
         assign a_tap[2] = coef.a2;
      end
   endgenerate

   assign x_tap[0] = x_ff;
   assign y_tap[0] = '0;
   generate
      for (genvar i = 1; i < TAPS; i++) begin : g_tap
         assign x_tap[i] = x_hist_ff[i-1];
         assign y_tap[i] = y_hist_ff[i-1];
      end
   endgenerate

   assign acc_hi = acc_ff[ACC_W-1:SPLIT_W];

   always_comb begin
      if (ctrl.scale_en) begin
         // acc * recip = recip * low + recip * high * 2^SPLIT_W
         mul_coef_a = coef.recip;
         mul_coef_b = coef.recip;
         opnd_a     = $signed({1'b0, acc_ff[SPLIT_W-1:0]});
         opnd_b     = OPND_W'(acc_hi);
      end else begin
         mul_coef_a = b_tap[step];
         mul_coef_b = a_tap[step];
         opnd_a     = OPND_W'(x_tap[step]);
         opnd_b     = OPND_W'(y_tap[step]);
      end
   end

   assign pa_in = mul_coef_a * opnd_a;
   assign pb_in = mul_coef_b * opnd_b;

   always_comb begin
      if (ctrl.load) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + ACC_W'(pa_ff) - ACC_W'(pb_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   assign x_in = ctrl.load ? sample : x_ff;

   // Rounding to nearest with halves toward positive infinity, then clamp.
   assign pa_ext = pa_ff;
   assign pb_ext = pb_ff;
   assign sum    = pa_ext + (pb_ext <<< SPLIT_W) + sisf_pkg::ROUND_BIAS;
   assign y_full = sum[SUM_W-1:sisf_pkg::OUT_SHIFT];

   always_comb begin
      if (y_full > YFULL_W'(sisf_pkg::SAMP_MAX)) begin
         y_sat = SAMP_W'(sisf_pkg::SAMP_MAX);
      end else if (y_full < YFULL_W'(sisf_pkg::SAMP_MIN)) begin
         y_sat = SAMP_W'(sisf_pkg::SAMP_MIN);
      end else begin
         y_sat = SAMP_W'(y_full);
      end
   end

   assign y_out = y_sat;

   always_comb begin
      for (int i = 0; i < TAPS - 1; i++) begin
         x_hist_in[i] = x_hist_ff[i];
         y_hist_in[i] = y_hist_ff[i];
      end
      if (ctrl.commit) begin
         x_hist_in[0] = x_ff;
         y_hist_in[0] = y_sat;
         for (int i = 1; i < TAPS - 1; i++) begin
            x_hist_in[i] = x_hist_ff[i-1];
            y_hist_in[i] = y_hist_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      acc_ff <= acc_in;
      if (ctrl.mul_en || ctrl.scale_en) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS - 1; i++) begin
            x_hist_ff[i] <= '0;
            y_hist_ff[i] <= '0;
         end
      end else begin
         x_hist_ff <= x_hist_in;
         y_hist_ff <= y_hist_in;
      end
   end

endmodule

// ===== src/sisf_ctrl.sv =====
// Sequencer that steps both lanes through the taps, scaling and rounding.
`timescale 1ns / 1ps

module sisf_ctrl #(
   parameter int  TAPS   = sisf_pkg::TAPS_DEFAULT,
   localparam int STEP_W = (TAPS > 1) ? $clog2(TAPS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               out_free,
   output logic               ready,
   output sisf_pkg::ctrl_type ctrl,
   output logic [STEP_W-1:0]  step
);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TAPS - 1);

   sisf_pkg::state_type state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                acc_en_ff, acc_en_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sisf_pkg::ST_IDLE;
         step_ff   <= '0;
         acc_en_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         acc_en_ff <= acc_en_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      ready         = 1'b0;
      ctrl.load     = 1'b0;
      ctrl.mul_en   = 1'b0;
      ctrl.scale_en = 1'b0;
      ctrl.commit   = 1'b0;
      // Products registered in a cycle are accumulated in the next.
      ctrl.acc_en   = acc_en_ff;
      unique case (state_ff)
         sisf_pkg::ST_IDLE: begin
            ready = 1'b1;
            if (req_valid) begin
               ctrl.load = 1'b1;
               step_in   = '0;
               state_in  = sisf_pkg::ST_MAC;
            end
         end
         sisf_pkg::ST_MAC: begin
            ctrl.mul_en = 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = sisf_pkg::ST_DRAIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         sisf_pkg::ST_DRAIN: begin
            // The last tap products are summed here.
            state_in = sisf_pkg::ST_SCALE;
         end
         sisf_pkg::ST_SCALE: begin
            ctrl.scale_en = 1'b1;
            state_in      = sisf_pkg::ST_ROUND;
         end
         sisf_pkg::ST_ROUND: begin
            if (out_free) begin
               ctrl.commit = 1'b1;
               state_in    = sisf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sisf_pkg::ST_IDLE;
         end
      endcase
   end

   assign acc_en_in = ctrl.mul_en;
   assign step      = step_ff;

endmodule

// ===== verif/sisf_frame_checker.sv =====
// Checker that predicts and compares the filtered stereo frames of the filter core.
`timescale 1ns / 1ps

module sisf_frame_checker #(
   parameter int TAPS = sisf_pkg::TAPS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [2*sisf_pkg::SAMP_W-1:0]     req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [2*sisf_pkg::SAMP_W-1:0]     rsp_tdata,
   input  logic                              csr_we,
   input  logic [sisf_pkg::REG_IDX_W-1:0]    csr_index,
   input  logic [sisf_pkg::COEF_W-1:0]       csr_wdata,
   output int                                fail_count,
   output int                                outstanding,
   output int                                checked_count
);

   localparam int SAMP_W    = sisf_pkg::SAMP_W;
   localparam int NUM_LANES = sisf_pkg::NUM_LANES;
   localparam int OUT_SHIFT = sisf_pkg::OUT_SHIFT;
   localparam int SAMP_MAX  = sisf_pkg::SAMP_MAX;
   localparam int SAMP_MIN  = sisf_pkg::SAMP_MIN;

   // Left lane in the low half, as on both data buses.
   typedef struct packed {
      logic signed [SAMP_W-1:0] right;
      logic signed [SAMP_W-1:0] left;
   } stereo_frame_type;

   sisf_pkg::coef_type       coefs;
   logic signed [SAMP_W-1:0] x_hist [NUM_LANES][2];
   logic signed [SAMP_W-1:0] y_hist [NUM_LANES][2];
   stereo_frame_type         expected_frames [$];

   task automatic report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      fail_count++;
   endtask

   // One lane of the direct-form-I section, exact accumulation then
   // round half up, floor shift and saturation.
   function automatic logic signed [SAMP_W-1:0] biquad_out(
      sisf_pkg::coef_type c,
      logic signed [SAMP_W-1:0] x, logic signed [SAMP_W-1:0] x1,
      logic signed [SAMP_W-1:0] x2, logic signed [SAMP_W-1:0] y1,
      logic signed [SAMP_W-1:0] y2);
      longint acc;
      longint prod;
      longint y;
      acc = longint'($signed(c.b0)) * longint'(x) + longint'($signed(c.b1)) * longint'(x1)
          - longint'($signed(c.a1)) * longint'(y1);
      if (TAPS > 2) begin
         acc += longint'($signed(c.b2)) * longint'(x2) - longint'($signed(c.a2)) * longint'(y2);
      end
      prod = acc * longint'($signed(c.recip)) + (longint'(1) <<< (OUT_SHIFT - 1));
      y = prod >>> OUT_SHIFT;
      if (y > SAMP_MAX) y = SAMP_MAX;
      if (y < SAMP_MIN) y = SAMP_MIN;
      return SAMP_W'(y);
   endfunction

   always @(posedge clock) begin
      stereo_frame_type in_frame;
      stereo_frame_type want;
      stereo_frame_type got;
      logic signed [SAMP_W-1:0] x [NUM_LANES];
      logic signed [SAMP_W-1:0] y [NUM_LANES];
      if (reset) begin
         coefs.b0    = sisf_pkg::COEF_ONE;
         coefs.b1    = sisf_pkg::COEF_ZERO;
         coefs.b2    = sisf_pkg::COEF_ZERO;
         coefs.a1    = sisf_pkg::COEF_ZERO;
         coefs.a2    = sisf_pkg::COEF_ZERO;
         coefs.recip = sisf_pkg::COEF_ONE;
         for (int l = 0; l < NUM_LANES; l++) begin
            x_hist[l] = '{default: '0};
            y_hist[l] = '{default: '0};
         end
         expected_frames.delete();
         fail_count    = 0;
         outstanding   = 0;
         checked_count = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_frame = req_tdata;
            x[0] = in_frame.left;
            x[1] = in_frame.right;
            for (int l = 0; l < NUM_LANES; l++) begin
               y[l] = biquad_out(coefs, x[l], x_hist[l][0], x_hist[l][1],
                                 y_hist[l][0], y_hist[l][1]);
               x_hist[l][1] = x_hist[l][0];
               x_hist[l][0] = x[l];
               y_hist[l][1] = y_hist[l][0];
               y_hist[l][0] = y[l];
            end
            want.left  = y[0];
            want.right = y[1];
            expected_frames.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_frames.size() == 0) begin
               report_mismatch($sformatf("result %h with no frame outstanding", rsp_tdata));
            end else begin
               want = expected_frames.pop_front();
               if (got.left !== want.left)
                  report_mismatch($sformatf("result %0d left_out %0d, expected %0d",
                                            checked_count, got.left, want.left));
               if (got.right !== want.right)
                  report_mismatch($sformatf("result %0d right_out %0d, expected %0d",
                                            checked_count, got.right, want.right));
               checked_count++;
            end
         end
         // Writes to indexes past the register list are dropped by the block.
         if (csr_we) begin
            case (csr_index)
               sisf_pkg::REG_B0:    coefs.b0    = csr_wdata;
               sisf_pkg::REG_B1:    coefs.b1    = csr_wdata;
               sisf_pkg::REG_B2:    coefs.b2    = csr_wdata;
               sisf_pkg::REG_A1:    coefs.a1    = csr_wdata;
               sisf_pkg::REG_A2:    coefs.a2    = csr_wdata;
               sisf_pkg::REG_RECIP: coefs.recip = csr_wdata;
               default: ;
            endcase
         end
         outstanding = expected_frames.size();
      end
   end

endmodule

// ===== verif/tb.sv =====
// Top of the filter core testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

   localparam int TAPS          = sisf_pkg::TAPS_DEFAULT;
   localparam int RANDOM_FRAMES = 1300;
   localparam int DRAIN_LIMIT   = 20000;

   localparam int SAMP_W    = sisf_pkg::SAMP_W;
   localparam int COEF_W    = sisf_pkg::COEF_W;
   localparam int REG_IDX_W = sisf_pkg::REG_IDX_W;

   localparam logic [COEF_W-1:0] COEF_ONE  = sisf_pkg::COEF_ONE;
   localparam logic [COEF_W-1:0] COEF_ZERO = sisf_pkg::COEF_ZERO;

   // Indexes past the register list; writes there must have no effect.
   localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef enum int {
      SET_UNITY,
      SET_SHELF,
      SET_FIRST_ORDER,
      SET_WILD,
      SET_EXTREME,
      SET_MUTE
   } setting_kind_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [2*SAMP_W-1:0]   req_tdata;    // left in, right in
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [2*SAMP_W-1:0]   rsp_tdata;    // left_out, right_out
   logic                  csr_we;
   logic [REG_IDX_W-1:0]  csr_index;
   logic [COEF_W-1:0]     csr_wdata;

   int   fail_count;
   int   outstanding;
   int   checked_count;
   bit   no_idle;
   int   sent_frames;
   int   settings_used;

   stereo_iir_shelving_filter_core #(.TAPS(TAPS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   sisf_frame_checker #(.TAPS(TAPS)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .checked_count (checked_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #5ms;
      $display("Timeout with %0d results outstanding", outstanding);
      $display("** stereo_iir_shelving_filter_core: FAILED **");
      $finish;
   end

   // Mostly short idle stretches, now and then a long one.
   function automatic int idle_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [SAMP_W-1:0] rand_sample();
      case ($urandom_range(0, 19))
         0:       return 16'h7fff;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'hffff;
         default: return SAMP_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] coef_between(int lo, int hi);
      return COEF_W'(lo + int'($urandom_range(0, hi - lo)));
   endfunction

   function automatic logic [COEF_W-1:0] coef_extreme();
      case ($urandom_range(0, 3))
         0:       return COEF_W'(-131072);
         1:       return COEF_W'(131071);
         2:       return COEF_ZERO;
         default: return COEF_ONE;
      endcase
   endfunction

   // Receiver side: random back-pressure, or none at all while no_idle is set.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (no_idle) begin
            stall_left = 0;
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < 30) begin
            stall_left = idle_length() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Called at a falling edge; returns at a falling edge after the transaction
   // and any idle gap that follows it.
   task automatic send_frame(logic [SAMP_W-1:0] left, logic [SAMP_W-1:0] right);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {right, left};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_frames++;
      @(negedge clock);
      gap = 0;
      if (!no_idle && $urandom_range(0, 99) < 35) gap = idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // Leaves csr_we high; the caller lowers it after the last write.
   task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic load_coefs(logic [COEF_W-1:0] b0, logic [COEF_W-1:0] b1,
                             logic [COEF_W-1:0] b2, logic [COEF_W-1:0] a1,
                             logic [COEF_W-1:0] a2, logic [COEF_W-1:0] recip);
      wait_idle();
      write_reg(sisf_pkg::REG_B0, b0);
      write_reg(sisf_pkg::REG_B1, b1);
      write_reg(sisf_pkg::REG_B2, b2);
      write_reg(sisf_pkg::REG_A1, a1);
      write_reg(sisf_pkg::REG_A2, a2);
      write_reg(sisf_pkg::REG_RECIP, recip);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int               random_sent;
      int               n_items;
      int               pause_at;
      int               waited;
      int               phase;
      setting_kind_type kind;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_we      = 1'b0;
      csr_index   = sisf_pkg::REG_B0;
      csr_wdata   = '0;
      no_idle     = 1'b0;
      sent_frames = 0;
      settings_used = 1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Coefficients after reset pass samples through unchanged.
      send_frame(16'h7fff, 16'h8000);
      send_frame(16'h8000, 16'h7fff);
      send_frame(16'h0000, 16'h0000);
      send_frame(16'hffff, 16'h0001);

      // Spare register indexes must leave the pass-through setting alone.
      wait_idle();
      write_reg(REG_SPARE_LO, COEF_W'(-131072));
      write_reg(REG_SPARE_HI, COEF_ZERO);
      csr_we <= 1'b0;
      send_frame(16'h1234, 16'hedcb);
      send_frame(16'h0001, 16'hffff);

      // Gain of one half shows rounding of exact halves toward plus infinity.
      load_coefs(COEF_W'(4096), COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE);
      send_frame(16'h0001, 16'hffff);
      send_frame(16'h0003, 16'hfffd);

      // Largest gain saturates the output both ways.
      load_coefs(COEF_W'(131071), COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE);
      send_frame(16'h7fff, 16'h8000);
      send_frame(16'h0064, 16'hff9c);
      send_frame(16'h0004, 16'hfffc);

      // Every coefficient at its most negative value.
      load_coefs(COEF_W'(-131072), COEF_W'(-131072), COEF_W'(-131072),
                 COEF_W'(-131072), COEF_W'(-131072), COEF_W'(-131072));
      send_frame(16'h7fff, 16'h8000);
      send_frame(16'h8000, 16'h7fff);
      send_frame(16'h0001, 16'hffff);

      // Every coefficient at its most positive value.
      load_coefs(COEF_W'(131071), COEF_W'(131071), COEF_W'(131071),
                 COEF_W'(131071), COEF_W'(131071), COEF_W'(131071));
      send_frame(16'h7fff, 16'h8000);
      send_frame(16'h0000, 16'h0000);

      // A zero reciprocal mutes the output whatever the history holds.
      load_coefs(COEF_ONE, COEF_ONE, COEF_ONE, COEF_ONE, COEF_ONE, COEF_ZERO);
      send_frame(16'h7fff, 16'h8000);
      send_frame(16'h4000, 16'hc000);

      // An integrator: the saturated output is what feeds back.
      load_coefs(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_W'(-8192), COEF_ZERO, COEF_ONE);
      send_frame(16'h4e20, 16'hb1e0);
      send_frame(16'h4e20, 16'hb1e0);
      send_frame(16'h4e20, 16'hb1e0);
      send_frame(16'h8000, 16'h7fff);

      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_FRAMES) begin
         kind = setting_kind_type'($urandom_range(SET_UNITY, SET_MUTE));
         if (kind == SET_MUTE && $urandom_range(0, 1) == 0) kind = SET_SHELF;
         case (kind)
            SET_UNITY:
               load_coefs(COEF_ONE, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE);
            SET_SHELF:
               load_coefs(coef_between(4000, 16000), coef_between(-16000, 16000),
                          coef_between(-8000, 8000), coef_between(-15000, 15000),
                          coef_between(-7500, 7500), coef_between(6000, 10000));
            SET_FIRST_ORDER:
               load_coefs(coef_between(2000, 12000), coef_between(-12000, 12000),
                          COEF_ZERO, coef_between(-8000, 8000), COEF_ZERO,
                          coef_between(6000, 10000));
            SET_WILD:
               load_coefs(coef_between(-131072, 131071), coef_between(-131072, 131071),
                          coef_between(-131072, 131071), coef_between(-131072, 131071),
                          coef_between(-131072, 131071), coef_between(-131072, 131071));
            SET_EXTREME:
               load_coefs(coef_extreme(), coef_extreme(), coef_extreme(),
                          coef_extreme(), coef_extreme(), coef_extreme());
            default:
               load_coefs(coef_between(-131072, 131071), coef_between(-131072, 131071),
                          coef_between(-131072, 131071), coef_between(-131072, 131071),
                          coef_between(-131072, 131071), COEF_ZERO);
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         n_items = $urandom_range(40, 120);
         // The first phase always holds off mid-way until every result is back.
         pause_at = (phase == 0 || $urandom_range(0, 2) == 0) ?
                    $urandom_range(1, n_items - 1) : -1;
         for (int i = 0; i < n_items; i++) begin
            if (i == pause_at) wait_idle();
            send_frame(rand_sample(), rand_sample());
            random_sent++;
         end
         phase++;
      end
      no_idle = 1'b0;

      req_tvalid <= 1'b0;
      waited = 0;
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (TAPS + 8) @(negedge clock);

      $display("Sent %0d stereo frames under %0d coefficient settings, %0d results checked.",
               sent_frames, settings_used, checked_count);
      if (outstanding != 0) $display("%0d results never arrived", outstanding);
      if (fail_count == 0 && outstanding == 0) begin
         $display("** stereo_iir_shelving_filter_core: PASSED **");
      end else begin
         $display("** stereo_iir_shelving_filter_core: FAILED **");
      end
      $finish;
   end

endmodule
